### hw/rtl/fpt_pkg.sv
// Shared types and constants for the Fermat all-bases primality tester.
// Used by fpt_ctrl, fpt_dp and fermat_primality_test_all_bases; no dependencies.
package fpt_pkg;

  localparam int CAND_W           = 16;  // candidate field width
  localparam int WIT_W            = 16;  // witness field width
  localparam int VERD_W           = 2;   // verdict field width
  localparam int NUMBER_WIDTH_DEF = 16;  // default internal number width

  typedef enum logic [VERD_W-1:0] {
    VERDICT_PRIME     = 2'd0,
    VERDICT_COMPOSITE = 2'd1,
    VERDICT_NONE      = 2'd2
  } verdict_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EXP_INIT,
    ST_SQ_START,
    ST_SQ_RUN,
    ST_SQ_END,
    ST_MB_START,
    ST_MB_RUN,
    ST_MB_END,
    ST_BIT_END,
    ST_CMP,
    ST_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic     load;          // capture candidate, base = n-1
    logic     exp_init;      // acc = 1, exponent bit index = top
    logic     mul_start;     // load multiplier operands
    logic     mul_sel_base;  // second operand: base (1) or acc (0)
    logic     mul_step;      // one double-and-add reduction step
    logic     mul_commit;    // acc = product
    logic     ebit_next;     // move to next lower exponent bit
    logic     base_dec;      // next base
    logic     res_write;     // load result register
    verdict_t verdict;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic n_small;     // n below 2
    logic n_even_big;  // n even and above 2
    logic mul_last;    // last multiplier step in progress
    logic ebit_set;    // current exponent bit is one
    logic ebit_last;   // current exponent bit is bit 0
    logic match;       // base^n mod n equals base
    logic base_one;    // base is 1
  } sts_t;

endpackage

### hw/rtl/fpt_ctrl.sv
// Sequencing state machine of the Fermat tester: walks bases, exponent bits
// and multiplier steps. Depends on fpt_pkg; drives fpt_dp through cmd_t.
module fpt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  fpt_pkg::sts_t sts,
  output fpt_pkg::cmd_t cmd
);

  fpt_pkg::state_t   state_r, state_nxt;
  fpt_pkg::verdict_t verdict_r, verdict_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fpt_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = fpt_pkg::ST_CHECK;
      end
      fpt_pkg::ST_CHECK: begin
        if (sts.n_small || sts.n_even_big) state_nxt = fpt_pkg::ST_FINISH;
        else                               state_nxt = fpt_pkg::ST_EXP_INIT;
      end
      fpt_pkg::ST_EXP_INIT: state_nxt = fpt_pkg::ST_SQ_START;
      fpt_pkg::ST_SQ_START: state_nxt = fpt_pkg::ST_SQ_RUN;
      fpt_pkg::ST_SQ_RUN: begin
        if (sts.mul_last) state_nxt = fpt_pkg::ST_SQ_END;
      end
      fpt_pkg::ST_SQ_END: begin
        if (sts.ebit_set) state_nxt = fpt_pkg::ST_MB_START;
        else              state_nxt = fpt_pkg::ST_BIT_END;
      end
      fpt_pkg::ST_MB_START: state_nxt = fpt_pkg::ST_MB_RUN;
      fpt_pkg::ST_MB_RUN: begin
        if (sts.mul_last) state_nxt = fpt_pkg::ST_MB_END;
      end
      fpt_pkg::ST_MB_END: state_nxt = fpt_pkg::ST_BIT_END;
      fpt_pkg::ST_BIT_END: begin
        if (sts.ebit_last) state_nxt = fpt_pkg::ST_CMP;
        else               state_nxt = fpt_pkg::ST_SQ_START;
      end
      fpt_pkg::ST_CMP: begin
        if (!sts.match || sts.base_one) state_nxt = fpt_pkg::ST_FINISH;
        else                            state_nxt = fpt_pkg::ST_EXP_INIT;
      end
      fpt_pkg::ST_FINISH: begin
        if (slot_free) state_nxt = fpt_pkg::ST_IDLE;
      end
      default: state_nxt = fpt_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    cmd.verdict   = verdict_r;
    in_tready     = 1'b0;
    verdict_nxt   = verdict_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    case (state_r)
      fpt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      fpt_pkg::ST_CHECK: begin
        // even n above 2: base n-1 gives (-1)^n = 1, never n-1
        if (sts.n_small)         verdict_nxt = fpt_pkg::VERDICT_NONE;
        else if (sts.n_even_big) verdict_nxt = fpt_pkg::VERDICT_COMPOSITE;
        else                     verdict_nxt = fpt_pkg::VERDICT_PRIME;
      end
      fpt_pkg::ST_EXP_INIT: cmd.exp_init = 1'b1;
      fpt_pkg::ST_SQ_START: cmd.mul_start = 1'b1;
      fpt_pkg::ST_SQ_RUN:   cmd.mul_step = 1'b1;
      fpt_pkg::ST_SQ_END:   cmd.mul_commit = 1'b1;
      fpt_pkg::ST_MB_START: begin
        cmd.mul_start    = 1'b1;
        cmd.mul_sel_base = 1'b1;
      end
      fpt_pkg::ST_MB_RUN:   cmd.mul_step = 1'b1;
      fpt_pkg::ST_MB_END:   cmd.mul_commit = 1'b1;
      fpt_pkg::ST_BIT_END:  cmd.ebit_next = !sts.ebit_last;
      fpt_pkg::ST_CMP: begin
        if (!sts.match)        verdict_nxt = fpt_pkg::VERDICT_COMPOSITE;
        else if (!sts.base_one) cmd.base_dec = 1'b1;
      end
      fpt_pkg::ST_FINISH: begin
        if (slot_free) begin
          cmd.res_write = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/fpt_dp.sv
// Datapath of the Fermat tester: candidate, base, power accumulator, a
// bit-serial modular multiplier and the result register. Depends on fpt_pkg.
module fpt_dp #(
  parameter int NUMBER_WIDTH = fpt_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic [fpt_pkg::CAND_W-1:0] candidate,
  input  fpt_pkg::cmd_t              cmd,
  output fpt_pkg::sts_t              sts,
  output logic [fpt_pkg::VERD_W-1:0] verdict,
  output logic [fpt_pkg::WIT_W-1:0]  witness
);

  localparam int W  = NUMBER_WIDTH;
  localparam int EW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]  n_r, base_r, acc_r;
  logic [W-1:0]  mul_a_r, mul_b_r, prod_r;
  logic [EW-1:0] mcnt_r, eidx_r;
  logic [fpt_pkg::VERD_W-1:0] verdict_r;
  logic [fpt_pkg::WIT_W-1:0]  witness_r;

  logic [fpt_pkg::CAND_W+W-1:0] cand_ext;
  logic [fpt_pkg::WIT_W+W-1:0]  base_ext;
  logic [W-1:0]   n_in;
  logic [W+1:0]   s, s_n, s_2n, n_x1, n_x2;
  logic [W-1:0]   red;

  assign cand_ext = {{W{1'b0}}, candidate};
  assign n_in     = cand_ext[W-1:0];
  assign base_ext = {{fpt_pkg::WIT_W{1'b0}}, base_r};

  // one interleaved step: prod = (2*prod + a_bit*b) mod n, sum below 3n
  assign n_x1 = {2'b00, n_r};
  assign n_x2 = {1'b0, n_r, 1'b0};
  assign s    = {1'b0, prod_r, 1'b0} + (mul_a_r[W-1] ? {2'b00, mul_b_r} : '0);
  assign s_n  = s - n_x1;
  assign s_2n = s - n_x2;

  always_comb begin
    if (s >= n_x2)      red = s_2n[W-1:0];
    else if (s >= n_x1) red = s_n[W-1:0];
    else                red = s[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r    <= n_in;
      base_r <= n_in - W'(1);
    end else if (cmd.base_dec) begin
      base_r <= base_r - W'(1);
    end

    if (cmd.exp_init) begin
      acc_r  <= W'(1);
      eidx_r <= EW'(W - 1);
    end else begin
      if (cmd.mul_commit) acc_r <= prod_r;
      if (cmd.ebit_next)  eidx_r <= eidx_r - EW'(1);
    end

    if (cmd.mul_start) begin
      mul_a_r <= acc_r;
      mul_b_r <= cmd.mul_sel_base ? base_r : acc_r;
      prod_r  <= '0;
      mcnt_r  <= EW'(W - 1);
    end else if (cmd.mul_step) begin
      mul_a_r <= mul_a_r << 1;
      prod_r  <= red;
      mcnt_r  <= mcnt_r - EW'(1);
    end

    if (cmd.res_write) begin
      verdict_r <= cmd.verdict;
      witness_r <= (cmd.verdict == fpt_pkg::VERDICT_COMPOSITE)
                   ? base_ext[fpt_pkg::WIT_W-1:0] : '0;
    end
  end

  always_comb begin
    sts.n_small    = (n_r >> 1) == '0;
    sts.n_even_big = !n_r[0] && (n_r > W'(2));
    sts.mul_last   = mcnt_r == '0;
    sts.ebit_set   = n_r[eidx_r];
    sts.ebit_last  = eidx_r == '0;
    sts.match      = acc_r == base_r;
    sts.base_one   = base_r == W'(1);
  end

  assign verdict = verdict_r;
  assign witness = witness_r;

endmodule

### hw/rtl/fermat_primality_test_all_bases.sv
// Fermat all-bases primality tester, top level: stream ports, controller and
// datapath. Depends on fpt_pkg, fpt_ctrl and fpt_dp.
//
// Takes one candidate n per item and returns one result per item: verdict
// 0 probably prime, 1 probably composite (witness = first failing base,
// counting down from n-1), 2 no verdict for n below 2. Items are handled one
// at a time. The cost is set by a bit-serial modular multiplier that retires
// one multiplier bit per cycle: with W = NUMBER_WIDTH each base tried takes
// one square per exponent bit, over all W bits of n, plus a multiply by the
// base for each set bit of n. Even n above 2 and n below 2 skip the test:
// the check state passes them straight to the finish state, which writes
// the result once the output register is free and returns to idle, where
// the next item can be taken. A finished result sits in an output register,
// and the next item is taken while it waits.
module fermat_primality_test_all_bases #(
  parameter int NUMBER_WIDTH = fpt_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [fpt_pkg::CAND_W-1:0] in_tdata,   // [15:0] candidate
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [fpt_pkg::WIT_W-1:0]  out_tdata,  // [15:0] witness
  output logic [fpt_pkg::VERD_W-1:0] out_tuser   // [1:0] verdict
);

  fpt_pkg::cmd_t cmd;
  fpt_pkg::sts_t sts;

  fpt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  fpt_dp #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_dp (
    .clk       (clk),
    .candidate (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .verdict   (out_tuser),
    .witness   (out_tdata)
  );

  // only composite results carry a witness
  a_witness_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != fpt_pkg::VERDICT_COMPOSITE) |-> out_tdata == '0)
    else $error("witness set on a non-composite result");

  // a failing base is never 0
  a_witness_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == fpt_pkg::VERDICT_COMPOSITE) |-> out_tdata != '0)
    else $error("composite result without witness");

  // an accepted item yields no result while its candidate is being checked
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared in the cycle after accept");

endmodule
